### sv/load_rebalance_transfer_planner_core_defines.svh
// Assertion macros shared by the planner modules.
`ifndef LOAD_REBALANCE_TRANSFER_PLANNER_CORE_DEFINES_SVH
`define LOAD_REBALANCE_TRANSFER_PLANNER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LRTP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LRTP_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRTP_ASSERT(label, clk, rst, prop, msg)
`define LRTP_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### sv/lrtp_pkg.sv
package lrtp_pkg;
   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_SEND = 2'd1;
   localparam logic [1:0] ACT_RECV = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  partner;
      logic [31:0] amount;
      logic        last_result;
   } rsp_type;
endpackage

### sv/lrtp_plan.sv
module lrtp_plan
   import lrtp_pkg::*;
#(
   parameter int MAX_RANKS = 16,
   parameter int IW = $clog2(MAX_RANKS),
   parameter int CW = $clog2(MAX_RANKS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [31:0]   in_load,
   input  logic          in_last,
   input  logic [3:0]    own_rank,
   output logic          out_valid,
   input  logic          out_ready,
   output rsp_type       out_data
);
   localparam int SW = 32 + CW;
   localparam logic [3:0] S_LOAD = 4'd0;
   localparam logic [3:0] S_DIV  = 4'd1;
   localparam logic [3:0] S_OWN  = 4'd2;
   localparam logic [3:0] S_SSCN = 4'd3;
   localparam logic [3:0] S_RSCN = 4'd4;
   localparam logic [3:0] S_STEP = 4'd5;
   localparam logic [3:0] S_EMIT = 4'd6;
   localparam logic [3:0] S_DONE = 4'd7;
   localparam logic [3:0] S_SRD  = 4'd8;
   localparam logic [3:0] S_RRD  = 4'd9;
   localparam logic [3:0] S_OWNR = 4'd10;
   localparam int KW = $clog2(MAX_RANKS);

   logic [31:0]   mem [MAX_RANKS];
   logic [31:0]   rd_ff;
   logic [IW-1:0] rd_addr;
   logic          rd_en;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, n_ff, n_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [31:0]   q_ff, q_in;
   logic [5:0]    dbit_ff, dbit_in;
   logic [CW-1:0] r_ff, r_in;
   logic [CW-1:0] sc_ff, sc_in, rc_ff, rc_in;
   logic [32:0]   sr_ff, sr_in, rr_ff, rr_in;
   logic [KW:0]   k_ff, k_in;
   logic          own_ok;
   logic [32:0]   tgt, mag;
   logic          is_surp, is_def;
   logic [CW-1:0] cur;
   logic [32:0]   t_amt;
   logic          pend_ff, pend_in;
   rsp_type       pend_d_ff, pend_d_in;
   logic          push;
   rsp_type       push_d;
   logic [SW-1:0] trial;
   logic          fin;

   // Classification of the entry just read (rd_ff) at rank cur.
   always_comb begin
      tgt = {1'b0, q_ff} + ((cur < r_ff) ? 33'd1 : 33'd0);
      is_surp = {1'b0, rd_ff} > tgt;
      is_def  = {1'b0, rd_ff} < tgt;
      mag = is_surp ? ({1'b0, rd_ff} - tgt) : (tgt - {1'b0, rd_ff});
      t_amt = (sr_ff < rr_ff) ? sr_ff : rr_ff;
      trial = {rem_ff[SW-2:0], sum_ff[SW-1]};
   end
   assign own_ok = 32'(own_rank) < 32'(n_ff);

   always_ff @(posedge clock) begin
      if (in_valid && in_ready && cnt_ff < CW'(MAX_RANKS)) begin
         mem[cnt_ff[IW-1:0]] <= in_load;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign in_ready = (state_ff == S_LOAD);
   assign fin = (state_ff == S_DONE);

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; n_in = n_ff; sum_in = sum_ff;
      rem_in = rem_ff; q_in = q_ff; dbit_in = dbit_ff; r_in = r_ff;
      sc_in = sc_ff; rc_in = rc_ff; sr_in = sr_ff; rr_in = rr_ff; k_in = k_ff;
      cur = sc_ff; rd_en = 1'b0; rd_addr = '0;
      push = 1'b0; push_d = '0;
      unique case (state_ff)
         S_LOAD: begin
            if (in_valid) begin
               if (cnt_ff < CW'(MAX_RANKS)) begin
                  cnt_in = cnt_ff + 1'b1;
                  sum_in = sum_ff + SW'(in_load);
               end
               if (in_last) begin
                  n_in = (cnt_ff < CW'(MAX_RANKS)) ? cnt_ff + 1'b1 : cnt_ff;
                  cnt_in = '0;
                  rem_in = '0; q_in = '0; dbit_in = 6'(SW);
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            // Restoring division, one quotient bit a cycle.
            if (trial >= SW'(n_ff)) begin
               rem_in = trial - SW'(n_ff);
               q_in = {q_ff[30:0], 1'b1};
            end else begin
               rem_in = trial;
               q_in = {q_ff[30:0], 1'b0};
            end
            sum_in = {sum_ff[SW-2:0], 1'b0};
            dbit_in = dbit_ff - 1'b1;
            if (dbit_ff == 6'd1) begin
               r_in = (trial >= SW'(n_ff)) ? CW'(trial - SW'(n_ff)) : CW'(trial);
               k_in = '0;
               if (own_ok) begin
                  rd_en = 1'b1; rd_addr = IW'(own_rank);
                  state_in = S_OWNR;
               end else begin
                  state_in = S_OWN;
               end
            end
         end
         S_OWNR: begin
            sc_in = CW'(own_rank);
            state_in = S_OWN;
         end
         S_OWN: begin
            cur = sc_ff;
            if (own_ok && (is_surp || is_def)) begin
               sc_in = '0; rc_in = '0;
               rr_in = '0;
               rd_en = 1'b1; rd_addr = '0;
               state_in = S_SRD;
            end else begin
               push = 1'b1;
               push_d = '{ACT_NONE, 4'd0, 32'd0, 1'b1};
               state_in = S_EMIT;
            end
         end
         S_SRD: state_in = S_SSCN;
         S_SSCN: begin
            cur = sc_ff;
            if (sc_ff < n_ff && !is_surp) begin
               sc_in = sc_ff + 1'b1;
               rd_en = 1'b1; rd_addr = IW'(sc_ff + 1'b1);
               state_in = S_SRD;
            end else begin
               if (sc_ff < n_ff) sr_in = mag;
               // A receiver with deficit left keeps it; only a used-up one is replaced.
               if (rr_ff == '0) begin
                  rd_en = 1'b1; rd_addr = IW'(rc_ff);
                  state_in = S_RRD;
               end else begin
                  state_in = S_STEP;
               end
            end
         end
         S_RRD: state_in = S_RSCN;
         S_RSCN: begin
            cur = rc_ff;
            if (rc_ff >= n_ff) begin
               state_in = S_STEP;
            end else if (is_def) begin
               rr_in = mag;
               state_in = S_STEP;
            end else begin
               rc_in = rc_ff + 1'b1;
               rd_en = 1'b1; rd_addr = IW'(rc_ff + 1'b1);
               state_in = S_RRD;
            end
         end
         S_STEP: begin
            if (sc_ff >= n_ff || rc_ff >= n_ff) begin
               if (k_ff == '0) begin
                  push = 1'b1;
                  push_d = '{ACT_NONE, 4'd0, 32'd0, 1'b1};
               end
               state_in = S_DONE;
            end else if (!pend_ff || out_ready) begin
               // Only one of the two matches can hold, since a rank is one kind.
               if (sc_ff == CW'(own_rank) && k_ff < (KW+1)'(MAX_RANKS - 1)) begin
                  push = 1'b1;
                  push_d = '{ACT_SEND, 4'(rc_ff), t_amt[31:0], 1'b0};
                  k_in = k_ff + 1'b1;
               end else if (rc_ff == CW'(own_rank) && k_ff < (KW+1)'(MAX_RANKS - 1)) begin
                  push = 1'b1;
                  push_d = '{ACT_RECV, 4'(sc_ff), t_amt[31:0], 1'b0};
                  k_in = k_ff + 1'b1;
               end
               sr_in = sr_ff - t_amt;
               rr_in = rr_ff - t_amt;
               if (sr_ff == t_amt) begin
                  sc_in = sc_ff + 1'b1;
                  rd_en = 1'b1; rd_addr = IW'(sc_ff + 1'b1);
                  state_in = S_SRD;
               end else begin
                  rc_in = rc_ff + 1'b1;
                  rd_en = 1'b1; rd_addr = IW'(rc_ff + 1'b1);
                  state_in = S_RRD;
               end
               if (sr_ff == t_amt && rr_ff == t_amt) begin
                  // Both advance: sender scan, then receiver scan from next.
                  rc_in = rc_ff + 1'b1;
               end
            end
         end
         S_DONE: state_in = S_EMIT;
         S_EMIT: begin
            if (!pend_ff) begin
               sum_in = '0;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   // Hold one result back so the last one can be marked before release.
   always_comb begin
      pend_in = pend_ff; pend_d_in = pend_d_ff; out_valid = 1'b0; out_data = pend_d_ff;
      if (pend_ff && (pend_d_ff.last_result || push || fin)) begin
         out_valid = 1'b1;
         out_data = pend_d_ff;
         if (fin && !push) out_data.last_result = 1'b1;
      end
      if (out_valid && out_ready) pend_in = 1'b0;
      if (fin && pend_ff && !out_ready) begin
         pend_d_in.last_result = 1'b1;
      end
      if (push) begin
         pend_in = 1'b1;
         pend_d_in = push_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff <= '0;
         sum_ff <= '0;
         pend_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         pend_ff <= pend_in;
         k_ff <= k_in;
      end
      n_ff <= n_in; rem_ff <= rem_in; q_ff <= q_in; dbit_ff <= dbit_in;
      r_ff <= r_in; sc_ff <= sc_in; rc_ff <= rc_in; sr_ff <= sr_in; rr_ff <= rr_in;
      pend_d_ff <= pend_d_in;
   end

   `include "load_rebalance_transfer_planner_core_defines.svh"
   `LRTP_ASSERT(a_push_space, clock, reset, push |-> (!pend_ff || out_ready), "result overwritten")
   `LRTP_ASSERT(a_load_only_idle, clock, reset, (in_valid && in_ready) |-> state_ff == S_LOAD, "load outside idle")
   `LRTP_ASSERT(a_k_bound, clock, reset, k_ff <= (KW+1)'(MAX_RANKS - 1), "too many results")
endmodule

### sv/lrtp_queue.sv
module lrtp_queue
   import lrtp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  rsp_type wr_data,
   output logic    rd_valid,
   input  logic    rd_ready,
   output rsp_type rd_data
);
   rsp_type    q_ff [2];
   logic [1:0] cnt_ff;
   logic       wp_ff, rp_ff;
   logic       wr, rd;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data = q_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr) q_ff[wp_ff] <= wr_data;
      if (reset) begin
         cnt_ff <= '0; wp_ff <= 1'b0; rp_ff <= 1'b0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
   end

   `include "load_rebalance_transfer_planner_core_defines.svh"
   `LRTP_ASSERT(a_q_cnt, clock, reset, cnt_ff != 2'd3, "queue count invalid")
   `LRTP_ASSERT(a_q_ptr, clock, reset, (cnt_ff == 2'd1) |-> (wp_ff != rp_ff), "queue pointers disagree")
   `LRTP_ASSERT(a_q_full, clock, reset, (cnt_ff == 2'd2) |-> (wp_ff == rp_ff), "queue full pointers")
endmodule

### sv/load_rebalance_transfer_planner_core.sv
// Channel | Ports                                   | Direction
// req     | req_push, req_full, req_load, req_last_load | in
// rsp     | rsp_pop, rsp_empty, rsp_action..last_result | out
// csr     | csr_valid, csr_ready, csr_own_rank          | in
// Loads are taken one per cycle until the last load of a set.
// Planning then runs a restoring division, classifies the own rank, scans the ranks
// for senders and receivers, takes matching steps and finishes.
// Reset is synchronous; it clears the set count and empties the result queue.
// A full result queue stalls the walk; new loads wait until the plan is emitted.
module load_rebalance_transfer_planner_core
   import lrtp_pkg::*;
#(
   parameter int MAX_RANKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_load,
   input  logic        req_last_load,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_action,
   output logic [3:0]  rsp_partner,
   output logic [31:0] rsp_amount,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_own_rank
);
   logic [3:0] own_ff;
   logic       pv, pr, qv;
   logic       rdy;
   rsp_type    pd, qd;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) own_ff <= '0;
      else if (csr_valid) own_ff <= csr_own_rank;
   end

   lrtp_plan #(.MAX_RANKS(MAX_RANKS)) u_plan (
      .clock, .reset, .in_valid(req_push), .in_ready(rdy), .in_load(req_load),
      .in_last(req_last_load), .own_rank(own_ff), .out_valid(pv), .out_ready(pr),
      .out_data(pd)
   );
   assign req_full = !rdy;

   lrtp_queue u_queue (
      .clock, .reset, .wr_valid(pv), .wr_ready(pr), .wr_data(pd),
      .rd_valid(qv), .rd_ready(rsp_pop), .rd_data(qd)
   );
   assign rsp_empty = !qv;
   assign rsp_action = qd.action;
   assign rsp_partner = qd.partner;
   assign rsp_amount = qd.amount;
   assign rsp_last_result = qd.last_result;
endmodule
